### hdl/ccrc_pkg.sv
// Shared constants, types and register indexes of the configurable CRC remainder block.
`timescale 1ns / 1ps
`default_nettype none

package ccrc_pkg;

   // Limits of the division datapath
   localparam int MAX_MSG_BITS = 64;
   localparam int MAX_DEGREE   = 32;

   // Division steps handled by one pipeline stage
   localparam int STEPS      = 8;
   localparam int NUM_STAGES = (MAX_MSG_BITS + STEPS - 1) / STEPS;
   localparam int PAD_BITS   = NUM_STAGES * STEPS;
   localparam int WORK_W     = PAD_BITS + MAX_DEGREE;

   // Field widths of the ports
   localparam int DATA_W     = 64;
   localparam int REM_W      = 32;
   localparam int GEN_W      = 33;
   localparam int DEG_W      = 6;
   localparam int LEN_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 33;

   // Widths of the saturated degree and message length
   localparam int DEG_SAT_W = $clog2(MAX_DEGREE + 1);
   localparam int LEN_SAT_W = $clog2(MAX_MSG_BITS + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_LENGTH = 2'd2;

   // Register reset values
   localparam logic [GEN_W-1:0] GEN_RESET = 33'd37;
   localparam logic [DEG_W-1:0] DEG_RESET = 6'd5;
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd32;

   // Running dividend: padded message bits above, one remainder window below
   typedef logic [WORK_W-1:0] work_type;

   // Settings derived from the registers, ready for the datapath
   typedef struct packed {
      logic [PAD_BITS-1:0]   en;    // step enable, one bit per dividend position
      logic [MAX_DEGREE-1:0] poly;  // generator low bits, top-aligned in the window
      logic [MAX_DEGREE-1:0] mask;  // remainder mask, low degree bits set
   } cfg_type;

endpackage

`default_nettype wire

### hdl/ccrc_csr.sv
// Configuration registers and the derived step enables, aligned polynomial and mask.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ccrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ccrc_pkg::CSR_DATA_W-1:0]  csr_data,
   output ccrc_pkg::cfg_type                     cfg
);
   import ccrc_pkg::*;

   logic [GEN_W-1:0] gen_ff, gen_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic [LEN_W-1:0] len_ff, len_in;
   cfg_type          cfg_ff, cfg_in;

   // Saturate degree and length, then build enables, mask and aligned polynomial
   function automatic cfg_type derive(input logic [GEN_W-1:0] gen,
                                      input logic [DEG_W-1:0] deg,
                                      input logic [LEN_W-1:0] len);
      cfg_type               c;
      logic [DEG_SAT_W-1:0]  deg_sat;
      logic [LEN_SAT_W-1:0]  len_sat;
      logic [MAX_DEGREE-1:0] g_low;
      deg_sat = (deg > DEG_W'(MAX_DEGREE)) ? DEG_SAT_W'(MAX_DEGREE) : deg[DEG_SAT_W-1:0];
      len_sat = (len > LEN_W'(MAX_MSG_BITS)) ? LEN_SAT_W'(MAX_MSG_BITS)
                                             : len[LEN_SAT_W-1:0];
      for (int j = 0; j < MAX_DEGREE; j++) begin
         c.mask[j] = (j < int'(deg_sat));
      end
      g_low  = gen[MAX_DEGREE-1:0] & c.mask;
      c.poly = g_low << (DEG_SAT_W'(MAX_DEGREE) - deg_sat);
      for (int p = 0; p < PAD_BITS; p++) begin
         c.en[p] = (p >= int'(deg_sat)) && (p < int'(len_sat));
      end
      return c;
   endfunction

   // Take a word into the addressed register; other indexes are dropped
   always_comb begin
      gen_in = gen_ff;
      deg_in = deg_ff;
      len_in = len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GENERATOR:  gen_in = csr_data[GEN_W-1:0];
            CSR_DEGREE:     deg_in = csr_data[DEG_W-1:0];
            CSR_MSG_LENGTH: len_in = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
      cfg_in = derive(gen_in, deg_in, len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_RESET;
         deg_ff <= DEG_RESET;
         len_ff <= LEN_RESET;
         cfg_ff <= derive(GEN_RESET, DEG_RESET, LEN_RESET);
      end else begin
         gen_ff <= gen_in;
         deg_ff <= deg_in;
         len_ff <= len_in;
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

### hdl/ccrc_stage.sv
// One pipeline stage: a group of conditional XOR-and-shift division steps.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire ccrc_pkg::work_type                in_w,
   input  wire logic [ccrc_pkg::STEPS-1:0]        en,
   input  wire logic [ccrc_pkg::MAX_DEGREE-1:0]   poly,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output ccrc_pkg::work_type                     out_w
);
   import ccrc_pkg::*;

   logic     valid_ff, valid_in;
   work_type w_ff;
   work_type w;
   work_type w_rot;

   // Test the top bits one by one; a set bit pulls the polynomial in below it
   always_comb begin
      w = in_w;
      for (int k = 0; k < STEPS; k++) begin
         if (en[STEPS-1-k] && w[WORK_W-1-k]) begin
            w[WORK_W-2-k -: MAX_DEGREE] = w[WORK_W-2-k -: MAX_DEGREE] ^ poly;
         end
      end
      // Rotate the finished bits to the bottom so the next stage sees its bits on top
      w_rot = {w[WORK_W-STEPS-1:0], w[WORK_W-1 -: STEPS]};
   end

   // Advance when the slot is empty or being drained
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         w_ff <= w_rot;
      end
   end

   assign out_valid = valid_ff;
   assign out_w     = w_ff;

endmodule

`default_nettype wire

### hdl/ccrc_out.sv
// Output register: masks the remainder window to the degree and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_out (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire ccrc_pkg::work_type                in_w,
   input  wire logic [ccrc_pkg::MAX_DEGREE-1:0]   mask,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ccrc_pkg::REM_W-1:0]             rsp_data
);
   import ccrc_pkg::*;

   logic             valid_ff, valid_in;
   logic [REM_W-1:0] data_ff, data_in;

   // After the full rotation the remainder sits in the lowest window bits
   assign data_in  = REM_W'(in_w[MAX_DEGREE-1:0] & mask);

   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the word while the consumer stalls
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### hdl/configurable_crc_remainder.sv
// Top level of the configurable CRC remainder block.
// Each req word is divided over GF(2) by the configured generator, without zero
// augmentation, and the low degree bits of the remainder come back as one rsp word.
// The division runs as a pipeline of eight stages of eight conditional XOR steps
// each, followed by an output register, and a new word is accepted every cycle
// while rsp_tready stays high. Backpressure stalls every full stage in place.
// Write the registers only while no word is in flight; a write takes effect for
// words accepted from the next cycle on. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module configurable_crc_remainder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: data_word[63:0]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [ccrc_pkg::DATA_W-1:0]      req_tdata,
   // rsp_tdata: remainder[31:0]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ccrc_pkg::REM_W-1:0]            rsp_tdata,
   // csr_index: 0 generator, 1 degree, 2 msg_length
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ccrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ccrc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ccrc_pkg::*;

   cfg_type  cfg;
   logic     valid_s [0:NUM_STAGES];
   logic     ready_s [0:NUM_STAGES];
   work_type w_s     [0:NUM_STAGES];

   ccrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Place the message bits above an empty remainder window
   assign valid_s[0] = req_tvalid;
   assign req_tready = ready_s[0];
   assign w_s[0]     = {PAD_BITS'(req_tdata[MAX_MSG_BITS-1:0]), {MAX_DEGREE{1'b0}}};

   // Division stages, highest dividend positions first
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      ccrc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[k]),
         .in_ready  (ready_s[k]),
         .in_w      (w_s[k]),
         .en        (cfg.en[PAD_BITS-1-k*STEPS -: STEPS]),
         .poly      (cfg.poly),
         .out_valid (valid_s[k+1]),
         .out_ready (ready_s[k+1]),
         .out_w     (w_s[k+1])
      );
   end

   ccrc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[NUM_STAGES]),
      .in_ready  (ready_s[NUM_STAGES]),
      .in_w      (w_s[NUM_STAGES]),
      .mask      (cfg.mask),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

### hdl/ccrc_checker.sv
// Port-level checks of the configurable CRC remainder block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tready,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [ccrc_pkg::REM_W-1:0]       rsp_tdata,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready
);

   // Reset empties the pipeline, so no word is offered right after it
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A draining output frees every stage, so the input side must be ready too
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp_tready high");

   // A stalled result word stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word dropped or changed");

   // Register writes are never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind configurable_crc_remainder ccrc_checker u_ccrc_checker (.*);

`default_nettype wire

### bench/tb.sv
// Testbench of the configurable CRC remainder block: directed and random words against a local divider.
`timescale 1ns / 1ps

module tb;
   import ccrc_pkg::*;

   // Settling margin in clock cycles after the last remainder is back
   localparam int PIPE_LATENCY = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 78;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [REM_W-1:0]      rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Local copy of the register file
   logic [GEN_W-1:0] generator_poly;
   logic [DEG_W-1:0] degree_bits;
   logic [LEN_W-1:0] length_bits;

   logic [REM_W-1:0] expected_remainders[$];
   int               mismatch_count;
   bit               steady_flow;

   configurable_crc_remainder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Divide one word over GF(2) with the current settings, no zero augmentation
   function automatic logic [REM_W-1:0] divide_word(logic [DATA_W-1:0] word);
      int               deg;
      int               len;
      logic [63:0]      running;
      logic [63:0]      keep;
      deg = int'(degree_bits);
      len = int'(length_bits);
      if (deg > MAX_DEGREE) deg = MAX_DEGREE;
      if (len > MAX_MSG_BITS) len = MAX_MSG_BITS;
      running = word;
      for (int pos = len - 1; pos >= deg; pos--) begin
         if (running[pos]) running = running ^ (64'(generator_poly) << (pos - deg));
      end
      keep = (64'd1 << deg) - 64'd1;
      return running[REM_W-1:0] & keep[REM_W-1:0];
   endfunction

   // Idle cycles before the next word on either side
   function automatic int draw_gap();
      if (steady_flow) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic report_mismatch(string what, logic [REM_W-1:0] got, logic [REM_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Send one data word; leaves tvalid high after the handshake
   task automatic send_word(logic [DATA_W-1:0] word);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      expected_remainders.push_back(divide_word(word));
   endtask

   // Drop tvalid and wait until every remainder is back and the pipe is empty
   task automatic drain_words();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_remainders.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_GENERATOR:  generator_poly = value[GEN_W-1:0];
         CSR_DEGREE:     degree_bits    = value[DEG_W-1:0];
         CSR_MSG_LENGTH: length_bits    = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Idle the block, then load all three registers
   task automatic apply_settings(logic [CSR_DATA_W-1:0] gen, logic [CSR_DATA_W-1:0] deg,
                                 logic [CSR_DATA_W-1:0] len);
      drain_words();
      write_register(CSR_GENERATOR, gen);
      write_register(CSR_DEGREE, deg);
      write_register(CSR_MSG_LENGTH, len);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Remainder check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_remainders.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, '0);
         end else begin
            logic [REM_W-1:0] want;
            want = expected_remainders.pop_front();
            if (rsp_tdata !== want) report_mismatch("remainder", rsp_tdata, want);
         end
      end
   end

   // Receiver stalls, drawn per word
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic test_reset_defaults();
      send_word(64'h0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0000_0000_8000_0000);
      // bits at and above the message length are ignored
      send_word(64'hFFFF_FFFF_0000_0000);
      send_word(64'h0000_0000_0000_001F);
   endtask

   task automatic test_full_width();
      apply_settings(33'h1_04C1_1DB7, 32, 64);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h8000_0000_0000_0000);
      send_word(64'h0123_4567_89AB_CDEF);
      // parity check with the smallest generator
      apply_settings(33'h3, 1, 64);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h8000_0000_0000_0001);
   endtask

   task automatic test_short_message();
      apply_settings(33'h107, 8, 8);
      send_word(64'hFFFF_FFFF_FFFF_FFAB);
      apply_settings(33'h3, 1, 1);
      send_word(64'h1);
      send_word(64'hFFFF_FFFF_FFFF_FFFE);
   endtask

   task automatic test_saturation();
      // degree and length above their limits clamp to the maximum
      apply_settings(33'h1_04C1_1DB7, 63, 127);
      send_word({$urandom, $urandom});
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      apply_settings(33'h1_EDB8_8320, 40, 100);
      send_word({$urandom, $urandom});
      // empty message
      apply_settings(33'h25, 5, 0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_degree_zero();
      apply_settings(33'h1, 0, 64);
      write_register(CSR_UNUSED, {1'($urandom_range(0, 1)), $urandom});
      @(negedge clock);
      csr_valid <= 1'b0;
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h1);
   endtask

   task automatic test_missing_leading_one();
      // bit 'degree' of the generator clear
      apply_settings(33'h7, 5, 32);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0000_0000_A5A5_A5A5);
      // generator bits above the degree must not matter
      apply_settings(33'h1_FFFF_FF25, 5, 32);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_random_settings();
      logic [CSR_DATA_W-1:0] gen;
      logic [CSR_DATA_W-1:0] deg_word;
      logic [CSR_DATA_W-1:0] len_word;
      logic [DATA_W-1:0]     word;
      int                    deg;
      int                    len;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin deg = 32; len = 64; end
            1:       begin deg = 1;  len = 1;  end
            2:       begin deg = 32; len = 32; end
            default: begin deg = $urandom_range(1, 32); len = $urandom_range(1, 64); end
         endcase
         gen = {1'($urandom_range(0, 1)), $urandom};
         if ($urandom_range(0, 3) != 0) gen[deg] = 1'b1;
         deg_word = CSR_DATA_W'(deg);
         len_word = CSR_DATA_W'(len);
         // garbage above the register width is dropped
         if (phase % 2 == 1) begin
            deg_word[CSR_DATA_W-1:DEG_W] = (CSR_DATA_W-DEG_W)'($urandom);
            len_word[CSR_DATA_W-1:LEN_W] = (CSR_DATA_W-LEN_W)'($urandom);
         end
         apply_settings(gen, deg_word, len_word);
         steady_flow = (phase % 4 == 3);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            word = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0:       word = '1;
               1:       word = 64'd1 << (len - 1);
               2:       word = word & {$urandom, $urandom} & {$urandom, $urandom};
               default: ;
            endcase
            send_word(word);
         end
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GENERATOR;
      csr_data       = '0;
      mismatch_count = 0;
      steady_flow    = 1'b0;
      generator_poly = GEN_RESET;
      degree_bits    = DEG_RESET;
      length_bits    = LEN_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_full_width();
      test_short_message();
      test_saturation();
      test_degree_zero();
      test_missing_leading_one();
      test_random_settings();

      drain_words();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0 && expected_remainders.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
